// ----- design/multi_timer_deadline_manager_macros.svh -----
// assertion macros for the multi-timer deadline manager
`ifndef MULTI_TIMER_DEADLINE_MANAGER_MACROS_SVH
`define MULTI_TIMER_DEADLINE_MANAGER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MTDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MTDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mtdm_pkg.sv -----
// shared types and constants for the multi-timer deadline manager
package mtdm_pkg;

  localparam int DefMaxTimers = 32;
  localparam int MaxResults   = 31;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  localparam logic [1:0] RK_EXPIRY = 2'd0;
  localparam logic [1:0] RK_ADD    = 2'd1;
  localparam logic [1:0] RK_SET    = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ADD,
    CMD_SET,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [4:0]  idx;
    logic [31:0] delay;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FLUSH
  } back_state_t;

endpackage

// ----- design/mtdm_front.sv -----
// front end: accepts transactions, decodes the operation and queues commands
module mtdm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_op,
  input  logic [4:0]     in_idx,
  input  logic [31:0]    in_delay,
  output logic           cmd_valid,
  input  logic           cmd_pop,
  output mtdm_pkg::cmd_t cmd
);
  import mtdm_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.idx   = in_idx;
    dec.delay = in_delay;
    unique case (in_op)
      OP_TICK: dec.kind = CMD_TICK;
      OP_ADD:  dec.kind = CMD_ADD;
      OP_SET:  dec.kind = CMD_SET;
      default: dec.kind = CMD_NOP;
    endcase
  end

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- design/mtdm_back.sv -----
// back end: timer state, deadline scan and result register
module mtdm_back #(
  parameter int MAX_TIMERS = mtdm_pkg::DefMaxTimers
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  mtdm_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [4:0]     out_id,
  output logic           out_acc,
  output logic           out_last
);
  import mtdm_pkg::*;

  localparam int SW = $clog2(MAX_TIMERS);
  localparam int CW = $clog2(MAX_TIMERS + 1);

  back_state_t state, state_next;

  logic [31:0]   count;
  logic [CW-1:0] used;
  logic [MAX_TIMERS-1:0] armed;
  logic [31:0]   mem [MAX_TIMERS];
  logic [31:0]   rd_data;
  logic [CW-1:0] rd_ptr;
  logic          p_valid;
  logic [SW-1:0] p_addr;
  logic          found;
  logic [SW-1:0] best;
  logic [31:0]   best_dl;
  logic          pend;
  logic [SW-1:0] pend_id;
  logic [4:0]    nfound;

  logic          out_free;
  logic          issue;
  logic          emit;
  logic [1:0]    e_kind;
  logic [4:0]    e_id;
  logic          e_acc;
  logic          e_last;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic          do_add;
  logic          do_set;
  logic          do_tick;

  logic [CW+4:0] idx_w;
  logic [CW+4:0] used_w;
  logic          set_ok;
  logic          add_ok;
  logic [SW+4:0] pend_w;
  logic [CW+4:0] used_id_w;

  assign out_free  = !out_valid || out_ready;
  assign issue     = (state == ST_SCAN) && (rd_ptr < used);
  assign idx_w     = {{CW{1'b0}}, cmd.idx};
  assign used_w    = {5'b0, used};
  assign set_ok    = (cmd.idx != 5'd0) && (idx_w < used_w);
  assign add_ok    = (used < CW'(MAX_TIMERS));
  assign pend_w    = {5'b0, pend_id};
  assign used_id_w = {5'b0, used};

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    e_kind     = RK_EXPIRY;
    e_id       = pend_w[4:0];
    e_acc      = 1'b1;
    e_last     = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = used[SW-1:0];
    do_add     = 1'b0;
    do_set     = 1'b0;
    do_tick    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_TICK: begin
              cmd_pop    = 1'b1;
              do_tick    = 1'b1;
              state_next = ST_SCAN;
            end
            CMD_ADD: begin
              if (out_free) begin
                cmd_pop = 1'b1;
                emit    = 1'b1;
                e_kind  = RK_ADD;
                e_acc   = add_ok;
                e_id    = add_ok ? used_id_w[4:0] : 5'd0;
                mem_we  = add_ok;
                do_add  = add_ok;
              end
            end
            CMD_SET: begin
              if (out_free) begin
                cmd_pop   = 1'b1;
                emit      = 1'b1;
                e_kind    = RK_SET;
                e_acc     = set_ok;
                e_id      = cmd.idx;
                mem_we    = set_ok;
                mem_waddr = idx_w[SW-1:0];
                do_set    = set_ok;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (!issue && !p_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!found) begin
          if (!pend) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!pend || out_free) begin
          emit       = pend;
          e_last     = 1'b0;
          state_next = (nfound == 5'(MaxResults - 1)) ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= count + cmd.delay;
    end
    if (issue) begin
      rd_data <= mem[rd_ptr[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= rd_ptr[SW-1:0];
    if (state != ST_SCAN) begin
      rd_ptr <= CW'(1);
    end else if (issue) begin
      rd_ptr <= rd_ptr + CW'(1);
    end
    if (p_valid && armed[p_addr] && (rd_data <= count) && (!found || rd_data < best_dl)) begin
      best    <= p_addr;
      best_dl <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      used    <= CW'(1);
      armed   <= '0;
      p_valid <= 1'b0;
      found   <= 1'b0;
      pend    <= 1'b0;
      pend_id <= '0;
      nfound  <= '0;
    end else begin
      p_valid <= issue;
      if (do_tick) begin
        count  <= count + 32'd1;
        found  <= 1'b0;
        pend   <= 1'b0;
        nfound <= '0;
      end
      if (do_add) begin
        armed[used[SW-1:0]] <= 1'b1;
        used                <= used + CW'(1);
      end
      if (do_set) begin
        armed[idx_w[SW-1:0]] <= 1'b1;
      end
      if (p_valid && armed[p_addr] && (rd_data <= count) && (!found || rd_data < best_dl)) begin
        found <= 1'b1;
      end
      if (state == ST_DECIDE && state_next != ST_DECIDE) begin
        found <= 1'b0;
        if (found) begin
          armed[best] <= 1'b0;
          pend        <= 1'b1;
          pend_id     <= best;
          nfound      <= nfound + 5'd1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (state == ST_FLUSH && state_next == ST_IDLE) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= e_kind;
      out_id   <= e_id;
      out_acc  <= e_acc;
      out_last <= e_last;
    end
  end

  `include "multi_timer_deadline_manager_macros.svh"

  `MTDM_ASSERT_NOW(a_flush_has_pend, state == ST_FLUSH, pend, "flush without pending expiry")
  `MTDM_ASSERT_NOW(a_expiry_nonzero, out_valid && out_kind == RK_EXPIRY, out_id != 5'd0, "expiry of reserved slot")
  `MTDM_ASSERT_NOW(a_used_range, 1'b1, used >= CW'(1) && used <= CW'(MAX_TIMERS), "slot count out of range")
  `MTDM_ASSERT_NOW(a_slot0_idle, 1'b1, !armed[0], "reserved slot armed")

endmodule

// ----- design/multi_timer_deadline_manager.sv -----
// top level of the multi-timer deadline manager
// usage:
//   s_axis carries commands: tuser is the operation (tick, add, set), tdata holds
//   the slot index and the delay in ticks. m_axis carries results: tuser is the
//   result kind, tdata holds timer id and accepted flag, tlast marks the last
//   result caused by one command.
//   a two-entry command queue sits between the decoder and the timer engine, so
//   commands are taken while the engine is busy or the output is stalled.
//   add and set give one acknowledge, loaded on the edge at which the command
//   leaves the queue. a tick scans slots 1 to slots_in_use-1 through the single
//   read port of the deadline memory, one slot a cycle, and runs one scan per
//   expiry plus a final one; a tick that reaches 31 expiries ends after the 31st
//   without a final scan. commands run one at a time. reset clears the tick count
//   and all armed flags and sets the slot count to 1, as slot 0 is reserved;
//   deadlines are written before use. a stall on m_axis holds the result
//   register and halts the engine when it next has a result to load; the queue
//   then fills and s_axis_tready drops.
module multi_timer_deadline_manager #(
  parameter int MAX_TIMERS = mtdm_pkg::DefMaxTimers
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slot_index, delay_ticks, zero pad
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // timer_id, accepted, zero pad
  output logic [1:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // last_of_run
);
  import mtdm_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  logic [4:0] out_id;
  logic       out_acc;

  mtdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_idx    (s_axis_tdata[4:0]),
    .in_delay  (s_axis_tdata[36:5]),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  mtdm_back #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_id    (out_id),
    .out_acc   (out_acc),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_acc, out_id};

endmodule

// ----- tb/sv/tb_multi_timer_deadline_manager.sv -----
// self-checking testbench for the multi-timer deadline manager
module tb_multi_timer_deadline_manager;
  import mtdm_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int NumSlots = DefMaxTimers;
  localparam int NumRandom = 150;
  localparam int IdleLimit = 6000;
  localparam int HoldCycles = 400;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [31:0] delay;
  } command_t;

  typedef struct {
    logic [1:0] kind;
    logic [4:0] id;
    logic       acc;
    logic       last;
  } event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  command_t commands[$];
  event_t   due_events[$];
  int       errors = 0;
  int       n_sent = 0;
  bit       calm = 1'b0;

  // predictor state
  bit [31:0] now_ticks;
  bit [31:0] deadline[NumSlots];
  bit        armed[NumSlots];
  int        used_slots;

  multi_timer_deadline_manager DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void push_event(input logic [1:0] kind, input int id, input bit acc);
    event_t e;
    e.kind = kind;
    e.id = id[4:0];
    e.acc = acc;
    e.last = 1'b0;
    due_events.push_back(e);
  endfunction

  function automatic void predict_results(input command_t c);
    int n;
    int best;
    int i;
    n = 0;
    if (c.op == OP_TICK) begin
      now_ticks = now_ticks + 32'd1;
      while (n < MaxResults) begin
        best = 0;
        for (i = 1; i < used_slots; i++) begin
          if (armed[i] && deadline[i] <= now_ticks) begin
            if (best == 0 || deadline[i] < deadline[best]) best = i;
          end
        end
        if (best == 0) break;
        armed[best] = 1'b0;
        push_event(RK_EXPIRY, best, 1'b1);
        n++;
      end
    end else if (c.op == OP_ADD) begin
      if (used_slots < NumSlots) begin
        deadline[used_slots] = now_ticks + c.delay;
        armed[used_slots] = 1'b1;
        push_event(RK_ADD, used_slots, 1'b1);
        used_slots++;
      end else begin
        push_event(RK_ADD, 0, 1'b0);
      end
      n = 1;
    end else if (c.op == OP_SET) begin
      if (c.idx > 0 && c.idx < used_slots) begin
        deadline[c.idx] = now_ticks + c.delay;
        armed[c.idx] = 1'b1;
        push_event(RK_SET, int'(c.idx), 1'b1);
      end else begin
        push_event(RK_SET, int'(c.idx), 1'b0);
      end
      n = 1;
    end
    if (n > 0) due_events[$].last = 1'b1;
  endfunction

  function automatic void add_command(input logic [1:0] op, input int idx, input logic [31:0] d);
    command_t c;
    c.op = op;
    c.idx = idx[4:0];
    c.delay = d;
    commands.push_back(c);
  endfunction

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 90) return $urandom_range(0, 40);
    return $urandom;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stimulus
  initial begin
    int r;
    int d;
    add_command(OP_TICK, 0, 32'd0);
    add_command(OP_IGNORED, 31, 32'hffff_ffff);
    add_command(OP_SET, 0, 32'd3);
    add_command(OP_SET, 31, 32'd3);
    add_command(OP_ADD, 0, 32'd0);
    add_command(OP_ADD, 31, 32'hffff_ffff);
    add_command(OP_ADD, 0, 32'd1);
    add_command(OP_ADD, 0, 32'd1);
    add_command(OP_SET, 3, 32'd0);
    add_command(OP_SET, 2, 32'h8000_0000);
    add_command(OP_TICK, 0, 32'd0);
    add_command(OP_TICK, 0, 32'd0);
    add_command(OP_SET, 1, 32'd2);
    add_command(OP_SET, 4, 32'd1);
    add_command(OP_TICK, 0, 32'd0);
    add_command(OP_TICK, 0, 32'd0);
    for (int k = 0; k < 6; k++) add_command(OP_ADD, k, pick_delay());
    while (commands.size() < NumRandom + 22) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // set slots 1 to NumSlots-1 to the same delay, then tick until that deadline passes
        d = $urandom_range(0, 2);
        for (int k = 1; k < NumSlots; k++) add_command(OP_SET, k, d);
        for (int k = 0; k <= d; k++) add_command(OP_TICK, 0, 32'd0);
      end else if (r < 45) add_command(OP_TICK, $urandom_range(0, 31), $urandom);
      else if (r < 70) add_command(OP_ADD, $urandom_range(0, 31), pick_delay());
      else if (r < 95) add_command(OP_SET, $urandom_range(0, 31), pick_delay());
      else add_command(OP_IGNORED, $urandom_range(0, 31), $urandom);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (commands.size() == 0 && !s_axis_tvalid);
    wait (due_events.size() == 0);
    repeat (1200) @(posedge clk);
    if (errors == 0 && due_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    bit busy;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      now_ticks = 0;
      used_slots = 1;
      for (int i = 0; i < NumSlots; i++) armed[i] = 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_results(commands.pop_front());
        n_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap > 0) in_gap--;
        if (in_gap == 0 && commands.size() > 0) begin
          s_axis_tuser <= commands[0].op;
          s_axis_tdata <= {3'b000, commands[0].delay, commands[0].idx};
          s_axis_tvalid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  out_hold = 0;
  bit  held = 1'b0;
  always @(posedge clk) begin
    event_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_events.size() == 0) begin
          report("unexpected transaction kind", int'(m_axis_tuser), -1);
        end else begin
          e = due_events.pop_front();
          if (m_axis_tuser !== e.kind)
            report("result_kind", int'(m_axis_tuser), int'(e.kind));
          if (m_axis_tdata[4:0] !== e.id)
            report("timer_id", int'(m_axis_tdata[4:0]), int'(e.id));
          if (m_axis_tdata[5] !== e.acc)
            report("accepted", int'(m_axis_tdata[5]), int'(e.acc));
          if (m_axis_tdata[7:6] !== 2'b00)
            report("tdata pad", int'(m_axis_tdata[7:6]), 0);
          if (m_axis_tlast !== e.last)
            report("last_of_run", int'(m_axis_tlast), int'(e.last));
        end
      end
      if ($urandom_range(0, 59) == 0) calm = ~calm;
      if (out_hold > 0) out_hold--;
      else if (!held && n_sent >= 60) begin
        out_hold = HoldCycles;
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 3) out_hold = $urandom_range(10, 40);
      else if (!calm && $urandom_range(0, 99) < 30) out_hold = $urandom_range(1, 2);
    end
    m_axis_tready <= !rst && out_hold == 0;
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

endmodule
